// File: hdl/btcd_pkg.sv
// ----------------------------------------------------------------------------
// Busy tone cadence detector package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package btcd_pkg;

  localparam int LINE_W    = 2;
  localparam int LINES_DEF = 4;
  localparam int RUN_W     = 8;
  localparam int CNT_W     = 7;
  localparam int NIB_W     = 4;
  localparam int CAD_W     = 4;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int TDATA_W   = 8;

  localparam logic [CNT_W-1:0] STALE_LIMIT_RST    = 7'd20;
  localparam logic [NIB_W-1:0] PERIOD_MIN_RST     = 4'd6;
  localparam logic [NIB_W-1:0] PERIOD_MAX_RST     = 4'd12;
  localparam logic [CAD_W-1:0] PERIODS_NEEDED_RST = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALE_LIMIT    = 2'd0,
    REG_PERIOD_MIN     = 2'd1,
    REG_PERIOD_MAX     = 2'd2,
    REG_PERIODS_NEEDED = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0] stale_limit;
    logic [NIB_W-1:0] period_min;
    logic [NIB_W-1:0] period_max;
    logic [CAD_W-1:0] periods_needed;
  } cfg_t;

  // run word: bit 7 last level, bits 6..0 run count
  typedef struct packed {
    logic [RUN_W-1:0] word;
    logic [CAD_W-1:0] cad;
  } line_state_t;

endpackage

// File: hdl/btcd_store.sv
// ----------------------------------------------------------------------------
// Line state store
// Per-line run and cadence memory, registered read, write-back
// forwarding and per-entry valid flags that stand for the cleared state.
// ----------------------------------------------------------------------------
module btcd_store
  import btcd_pkg::*;
#(
  parameter int LINES = LINES_DEF,
  parameter int AW    = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  line_state_t   wr_state,
  output line_state_t   rd_state
);

  line_state_t      mem [LINES];
  logic [LINES-1:0] vld;
  line_state_t      mem_q;
  logic             vld_q;
  logic [AW-1:0]    rd_addr_q;
  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  line_state_t      fwd_state;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_state;
      fwd_addr     <= wr_addr;
      fwd_state    <= wr_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      vld_q     <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
        fwd_valid    <= 1'b1;
      end
    end
  end

  // take the latest write-back of the same line ahead of the memory word
  always_comb begin
    if (fwd_valid && (fwd_addr == rd_addr_q)) begin
      rd_state = fwd_state;
    end else if (vld_q) begin
      rd_state = mem_q;
    end else begin
      rd_state = '0;
    end
  end

endmodule

// File: hdl/btcd_update.sv
// ----------------------------------------------------------------------------
// Line state update
// Run counting, cadence judgement on level change and busy decision.
// ----------------------------------------------------------------------------
module btcd_update
  import btcd_pkg::*;
(
  input  cfg_t        cfg,
  input  logic        level,
  input  line_state_t cur,
  output line_state_t nxt,
  output logic        busy
);

  logic             last;
  logic [RUN_W-1:0] base;
  logic [NIB_W-1:0] nib;
  logic [RUN_W-1:0] word_n;
  logic [CAD_W-1:0] cad_n;

  always_comb begin
    last   = cur.word[RUN_W-1];
    nib    = cur.word[NIB_W-1:0];
    base   = cur.word;
    word_n = cur.word;
    cad_n  = cur.cad;
    if (level == last) begin
      if (cur.word[CNT_W-1:0] > cfg.stale_limit) begin
        base = {level, {CNT_W{1'b0}}};
      end
      word_n = base + RUN_W'(1);
    end else begin
      if ((nib > cfg.period_min) && (nib < cfg.period_max)) begin
        cad_n = cur.cad + CAD_W'(1);
      end else begin
        cad_n = '0;
      end
      word_n = {level, {CNT_W{1'b0}}};
    end
    busy = (cad_n >= cfg.periods_needed);
    if (busy) begin
      nxt.word = '0;
      nxt.cad  = '0;
    end else begin
      nxt.word = word_n;
      nxt.cad  = cad_n;
    end
  end

endmodule

// File: hdl/busy_tone_cadence_detector.sv
// ----------------------------------------------------------------------------
// Busy tone cadence detector
// A request is registered into stage one, its result into the output
// register with m_tvalid; stage one holds while the output stalls.
// Throughput: one request per cycle unless the output stalls, set by the
// single read-modify-write of line state with forwarding of the last write-back.
// Reset: configuration takes its defaults and every line entry reads as zero
// at once through per-entry valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module busy_tone_cadence_detector
  import btcd_pkg::*;
#(
  parameter int LINES = LINES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TDATA_W-1:0]   s_tdata,   // [1:0] line, [2] level
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata    // [1:0] line_out, [2] busy_detected
);

  localparam int LINE_AW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int IDX_W   = (LINE_AW > LINE_W) ? LINE_AW : LINE_W;

  cfg_t               cfg;
  logic [LINE_W-1:0]  in_line;
  logic               in_level;
  logic [IDX_W-1:0]   line_ext;
  logic               in_range;
  logic [LINE_AW-1:0] rd_addr;
  logic               s_acc;

  logic               s1_valid;
  logic [LINE_W-1:0]  s1_line;
  logic               s1_level;
  logic               s1_in_range;
  logic [LINE_AW-1:0] s1_addr;
  logic               s1_adv;

  line_state_t        cur_state;
  line_state_t        nxt_state;
  logic               upd_busy;
  logic               wr_en;

  logic [LINE_W-1:0]  m_line;
  logic               m_busy;

  assign in_line  = s_tdata[LINE_W-1:0];
  assign in_level = s_tdata[LINE_W];
  assign line_ext = IDX_W'(in_line);
  assign in_range = (32'(in_line) < 32'(LINES));
  assign rd_addr  = in_range ? line_ext[LINE_AW-1:0] : '0;

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign s_acc    = s_tvalid && s_tready;
  assign wr_en    = s1_adv && s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stale_limit    <= STALE_LIMIT_RST;
      cfg.period_min     <= PERIOD_MIN_RST;
      cfg.period_max     <= PERIOD_MAX_RST;
      cfg.periods_needed <= PERIODS_NEEDED_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STALE_LIMIT:    cfg.stale_limit    <= cfg_data[CNT_W-1:0];
        REG_PERIOD_MIN:     cfg.period_min     <= cfg_data[NIB_W-1:0];
        REG_PERIOD_MAX:     cfg.period_max     <= cfg_data[NIB_W-1:0];
        REG_PERIODS_NEEDED: cfg.periods_needed <= cfg_data[CAD_W-1:0];
        default: ;
      endcase
    end
  end

  btcd_store #(
    .LINES (LINES),
    .AW    (LINE_AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (s_acc),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (s1_addr),
    .wr_state (nxt_state),
    .rd_state (cur_state)
  );

  btcd_update u_update (
    .cfg   (cfg),
    .level (s1_level),
    .cur   (cur_state),
    .nxt   (nxt_state),
    .busy  (upd_busy)
  );

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_line     <= in_line;
      s1_level    <= in_level;
      s1_in_range <= in_range;
      s1_addr     <= rd_addr;
    end
    if (s1_adv) begin
      m_line <= s1_line;
      m_busy <= s1_in_range && upd_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(TDATA_W - LINE_W - 1){1'b0}}, m_busy, m_line};

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid && !m_tready))
    else $error("input held back without an output stall");

  a_write_on_advance: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (s1_valid && s1_in_range))
    else $error("state write-back without a request in stage one");

  a_busy_clears_line: assert property (@(posedge clk) disable iff (rst)
    (wr_en && upd_busy) |-> ((nxt_state.word == '0) && (nxt_state.cad == '0)))
    else $error("busy decision did not clear the line state");

  a_output_drains: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !s1_adv) |=> !m_tvalid)
    else $error("result repeated after it was taken");

endmodule
